@@ rtl/command_frame_validator_unit_assert.svh @@
`ifndef COMMAND_FRAME_VALIDATOR_UNIT_ASSERT_SVH
`define COMMAND_FRAME_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define CFVU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define CFVU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks the reset path itself.
`define CFVU_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cfvu_pkg.sv @@
package cfvu_pkg;

    // Message ids
    localparam logic [15:0] ID_FILL_0       = 16'h0000;
    localparam logic [15:0] ID_FILL_1       = 16'h0001;
    localparam logic [15:0] ID_SET_TIME     = 16'h0002;
    localparam logic [15:0] ID_OBS_START    = 16'h0003;
    localparam logic [15:0] ID_OBS_CTRL     = 16'h0004;
    localparam logic [15:0] ID_PED_CTRL     = 16'h0005;
    localparam logic [15:0] ID_DUMP         = 16'h0006;
    localparam logic [15:0] ID_SET_CFG      = 16'h0007;
    localparam logic [15:0] ID_BANK_A       = 16'h0008;
    localparam logic [15:0] ID_BANK_B       = 16'h0009;
    localparam logic [15:0] ID_TEST_RESULT  = 16'h000A;
    localparam logic [15:0] ID_FILL_11      = 16'h000B;
    localparam logic [15:0] ID_FILL_12      = 16'h000C;
    localparam logic [15:0] ID_SET_TIME_ALT = 16'h0401;
    localparam logic [15:0] ID_SET_REMOTE   = 16'h0A61;
    localparam logic [15:0] ID_SET_LOCAL    = 16'h0A62;
    localparam logic [15:0] ID_TIME_SYNC    = 16'hF210;
    localparam logic [15:0] ID_MAGFIELD     = 16'hF221;
    localparam logic [15:0] ID_ORBIT        = 16'h0100;

    // Lengths
    localparam logic [11:0] LEN_SHORT     = 12'd6;
    localparam logic [11:0] LEN_SET_CFG   = 12'd66;
    localparam logic [11:0] LEN_TIME_SYNC = 12'd125;
    localparam logic [11:0] LEN_MAGFIELD  = 12'd76;
    localparam logic [11:0] LEN_ORBIT     = 12'd24;

    localparam logic [7:0]  FILL_BYTE    = 8'hAA;
    localparam logic [7:0]  CMD_RSV_MASK = 8'hE0;
    localparam logic [15:0] MS_LIMIT     = 16'd1000;

    // Result codes
    localparam logic       KIND_EVENT = 1'b0;
    localparam logic       KIND_ACK   = 1'b1;
    localparam logic [1:0] ACK_OK     = 2'd0;
    localparam logic [1:0] ACK_CONTENT = 2'd1;
    localparam logic [1:0] ACK_WRONG_ID = 2'd2;
    localparam logic [1:0] BANK_ONE   = 2'd1;
    localparam logic [1:0] BANK_TWO   = 2'd2;
    localparam logic [3:0] EVT_SET_TIME  = 4'd2;
    localparam logic [3:0] EVT_TIME_SYNC = 4'd13;
    localparam logic [3:0] EVT_MAGFIELD  = 4'd14;
    localparam logic [3:0] EVT_ORBIT     = 4'd15;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BROADCAST = 1'd0;
    localparam t_cfg_idx CFG_REMOTE    = 1'd1;

    typedef struct packed {
        logic [15:0] msg_id;
        logic [15:0] dest_address;
        logic [11:0] length_bytes;
        logic [47:0] payload_bytes;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  event_type;
        logic [15:0] echo_id;
        logic [1:0]  ack_status;
        logic [1:0]  bank_select;
        logic [7:0]  flag_bits;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [15:0] local_address;
        logic [15:0] remote_address;
    } t_out_item;

    function automatic logic f_bank_ok(input logic [1:0] bank);
        f_bank_ok = (bank == BANK_ONE) || (bank == BANK_TWO);
    endfunction

    // Observe parameter word rules
    function automatic logic f_params_ok(input logic [15:0] p);
        logic [2:0] em;
        logic [2:0] ec;
        logic [1:0] sm;
        logic [2:0] hm;
        em = p[2:0];
        ec = p[5:3];
        sm = p[7:6];
        hm = p[10:8];
        f_params_ok = (em <= 3'd6) && (ec <= 3'd5) && (sm <= 2'd2) && (hm <= 3'd4) &&
                      !p[11] && !((sm == 2'd0 || sm == 2'd2) && hm != 3'd0);
    endfunction

endpackage

@@ rtl/cfvu_decode.sv @@
module cfvu_decode #(
    parameter int DUMP_PACKET_BYTES = 512
) (
    input  cfvu_pkg::t_in_item  i_item,
    input  logic [15:0]         i_own_address,
    input  logic [15:0]         i_partner_address,
    input  logic [15:0]         i_broadcast_address,
    output logic                o_keep,
    output cfvu_pkg::t_out_item o_res
);

    localparam int DUMP_W = $clog2(DUMP_PACKET_BYTES + 1);
    localparam int PROD_W = (24 + DUMP_W > 33) ? 24 + DUMP_W : 33;

    logic [7:0]        d0, d1, d2, d3, d4, d5;
    logic [15:0]       id;
    logic [11:0]       len;
    logic              is_short;
    logic              fill_all;
    logic              fill_tail;
    logic              bad;
    logic              is_cmd;
    logic [23:0]       dump_cnt;
    logic [PROD_W-1:0] dump_size;
    logic              dump_ovf;
    logic [15:0]       ms;

    assign {d5, d4, d3, d2, d1, d0} = i_item.payload_bytes;
    assign id        = i_item.msg_id;
    assign len       = i_item.length_bytes;
    assign is_short  = (len == cfvu_pkg::LEN_SHORT);
    assign fill_all  = (i_item.payload_bytes == {6{cfvu_pkg::FILL_BYTE}});
    assign fill_tail = (i_item.payload_bytes[47:8] == {5{cfvu_pkg::FILL_BYTE}});
    assign dump_cnt  = {d3, d2, d1};
    assign dump_size = PROD_W'(dump_cnt) * PROD_W'(DUMP_PACKET_BYTES);
    assign dump_ovf  = |dump_size[PROD_W-1:32];
    assign ms        = {d1, d0};

    always_comb begin
        o_res                = '0;
        o_res.echo_id        = id;
        o_res.local_address  = i_own_address;
        o_res.remote_address = i_partner_address;
        o_keep               = 1'b0;
        bad                  = 1'b0;
        is_cmd               = 1'b0;

        if (i_item.dest_address == i_own_address ||
            i_item.dest_address == i_broadcast_address) begin
            o_keep = 1'b1;
            case (id)
                cfvu_pkg::ID_SET_REMOTE, cfvu_pkg::ID_SET_LOCAL: begin
                    o_res.result_kind = cfvu_pkg::KIND_ACK;
                    if (!is_short || d0 == 8'd0) begin
                        o_res.ack_status = cfvu_pkg::ACK_CONTENT;
                    end else if (id == cfvu_pkg::ID_SET_REMOTE) begin
                        o_res.remote_address = {8'd0, d0};
                    end else begin
                        o_res.local_address = {8'd0, d0};
                    end
                end
                cfvu_pkg::ID_FILL_0, cfvu_pkg::ID_FILL_1,
                cfvu_pkg::ID_FILL_11, cfvu_pkg::ID_FILL_12: begin
                    is_cmd = 1'b1;
                    bad    = (len < cfvu_pkg::LEN_SHORT) || !fill_all;
                end
                cfvu_pkg::ID_SET_TIME: begin
                    is_cmd       = 1'b1;
                    o_res.word_b = {16'd0, ms};
                    o_res.word_a = {d5, d4, d3, d2};
                    bad          = !is_short || (ms >= cfvu_pkg::MS_LIMIT);
                end
                cfvu_pkg::ID_SET_TIME_ALT: begin
                    is_cmd       = 1'b1;
                    o_res.word_a = {d3, d2, d1, d0};
                    bad          = !is_short;
                end
                cfvu_pkg::ID_OBS_START: begin
                    is_cmd            = 1'b1;
                    o_res.word_a      = {16'd0, d2, d1};
                    o_res.word_b      = {16'd0, d4, d3};
                    o_res.bank_select = d0[1:0];
                    bad = !is_short || d5 != cfvu_pkg::FILL_BYTE ||
                          !cfvu_pkg::f_bank_ok(d0[1:0]) ||
                          !cfvu_pkg::f_params_ok({d2, d1});
                    o_res.flag_bits = {2'b00, d0[7], d0[6], d0[4], d0[3], d0[2], d0[5]};
                end
                cfvu_pkg::ID_OBS_CTRL: begin
                    is_cmd       = 1'b1;
                    o_res.word_a = {16'd0, d2, d1};
                    o_res.word_b = {16'd0, d4, d3};
                    bad = !is_short || d5 != cfvu_pkg::FILL_BYTE || d0[1:0] != 2'b11 ||
                          (d0 & cfvu_pkg::CMD_RSV_MASK) != 8'd0 ||
                          !cfvu_pkg::f_params_ok({d2, d1});
                    // inhibit unless powered, awake and registered
                    o_res.flag_bits = {1'b0, (!d0[2] || d0[3] || !d0[4]), 2'b00,
                                       d0[4], d0[3], d0[2], 1'b0};
                end
                cfvu_pkg::ID_PED_CTRL: begin
                    is_cmd            = 1'b1;
                    o_res.bank_select = d0[1:0];
                    bad = !is_short || !fill_tail || !cfvu_pkg::f_bank_ok(d0[1:0]) ||
                          (d0 & cfvu_pkg::CMD_RSV_MASK) != 8'd0;
                    o_res.flag_bits = {5'd0, d0[4], d0[3], d0[2]};
                end
                cfvu_pkg::ID_DUMP: begin
                    is_cmd            = 1'b1;
                    o_res.bank_select = d0[1:0];
                    o_res.word_a      = {8'd0, dump_cnt};
                    bad = !is_short || d4 != cfvu_pkg::FILL_BYTE ||
                          d5 != cfvu_pkg::FILL_BYTE || !cfvu_pkg::f_bank_ok(d0[1:0]) ||
                          (d0 & cfvu_pkg::CMD_RSV_MASK) != 8'd0 || d0[3] ||
                          (!d0[4] && dump_cnt == 24'd0) || dump_ovf;
                    o_res.word_b    = d0[4] ? 32'd0 : dump_size[31:0];
                    o_res.flag_bits = {d0[4], 6'd0, d0[2]};
                end
                cfvu_pkg::ID_SET_CFG: begin
                    is_cmd       = 1'b1;
                    o_res.word_a = {16'd0, ms};
                    bad          = (len != cfvu_pkg::LEN_SET_CFG);
                end
                cfvu_pkg::ID_BANK_A, cfvu_pkg::ID_BANK_B: begin
                    is_cmd            = 1'b1;
                    o_res.bank_select = d0[1:0];
                    bad = !is_short || !fill_tail || !cfvu_pkg::f_bank_ok(d0[1:0]) ||
                          d0[7:3] != 5'd0;
                    o_res.flag_bits = {7'd0, d0[2]};
                end
                cfvu_pkg::ID_TEST_RESULT: begin
                    is_cmd            = 1'b1;
                    o_res.bank_select = d0[1:0];
                    bad = !is_short || !fill_tail || !cfvu_pkg::f_bank_ok(d0[1:0]) ||
                          d0[7:2] != 6'd0;
                end
                cfvu_pkg::ID_TIME_SYNC: begin
                    o_keep           = (len == cfvu_pkg::LEN_TIME_SYNC);
                    o_res.event_type = cfvu_pkg::EVT_TIME_SYNC;
                end
                cfvu_pkg::ID_MAGFIELD: begin
                    o_keep           = (len == cfvu_pkg::LEN_MAGFIELD);
                    o_res.event_type = cfvu_pkg::EVT_MAGFIELD;
                end
                cfvu_pkg::ID_ORBIT: begin
                    o_keep           = (len == cfvu_pkg::LEN_ORBIT);
                    o_res.event_type = cfvu_pkg::EVT_ORBIT;
                end
                default: begin
                    o_res.result_kind = cfvu_pkg::KIND_ACK;
                    o_res.ack_status  = cfvu_pkg::ACK_WRONG_ID;
                end
            endcase

            if (is_cmd) begin
                o_res.event_type = (id == cfvu_pkg::ID_SET_TIME_ALT) ?
                                   cfvu_pkg::EVT_SET_TIME : id[3:0];
                // collapse a failed command into a bare content-error ack
                if (bad) begin
                    o_res.result_kind = cfvu_pkg::KIND_ACK;
                    o_res.ack_status  = cfvu_pkg::ACK_CONTENT;
                    o_res.event_type  = 4'd0;
                    o_res.bank_select = 2'd0;
                    o_res.flag_bits   = 8'd0;
                    o_res.word_a      = 32'd0;
                    o_res.word_b      = 32'd0;
                end
            end
        end
    end

endmodule

@@ rtl/command_frame_validator_unit.sv @@
// A transaction accepted into the input register is decoded and then captured in the
// result register. Throughput: one transaction per cycle while the output is not
// stalled; one input register and one result register, decode logic between them.
// Items for another node and telemetry of wrong length give no result.
// Reset (synchronous, active low) empties both registers and sets the broadcast,
// local and remote addresses to zero.
module command_frame_validator_unit #(
    parameter int DUMP_PACKET_BYTES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cfvu_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cfvu_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_we,
    input  cfvu_pkg::t_cfg_idx    i_cfg_idx,
    input  logic [15:0]           i_cfg_wdata
);

    logic                r_in_valid, n_in_valid;
    cfvu_pkg::t_in_item  r_in, n_in;
    logic                r_out_valid, n_out_valid;
    cfvu_pkg::t_out_item r_out, n_out;
    logic [15:0]         r_bcast, n_bcast;
    logic [15:0]         r_own, n_own;
    logic [15:0]         r_partner, n_partner;

    logic                out_ready;
    logic                advance;
    logic                in_take;
    logic                dec_keep;
    cfvu_pkg::t_out_item dec_res;

    cfvu_decode #(
        .DUMP_PACKET_BYTES(DUMP_PACKET_BYTES)
    ) u_decode (
        .i_item              (r_in),
        .i_own_address       (r_own),
        .i_partner_address   (r_partner),
        .i_broadcast_address (r_bcast),
        .o_keep              (dec_keep),
        .o_res               (dec_res)
    );

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in        = r_in;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_bcast     = r_bcast;
        n_own       = r_own;
        n_partner   = r_partner;

        if (in_take) begin
            n_in_valid = 1'b1;
            n_in       = i_in_data;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        if (advance) begin
            n_out_valid = dec_keep;
            if (dec_keep) begin
                n_out     = dec_res;
                n_own     = dec_res.local_address;
                n_partner = dec_res.remote_address;
            end
        end else if (out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                cfvu_pkg::CFG_BROADCAST: begin
                    n_bcast = i_cfg_wdata;
                    n_own   = i_cfg_wdata;
                end
                cfvu_pkg::CFG_REMOTE: begin
                    n_partner = i_cfg_wdata;
                end
                default: begin
                    n_bcast = r_bcast;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bcast     <= 16'd0;
            r_own       <= 16'd0;
            r_partner   <= 16'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_bcast     <= n_bcast;
            r_own       <= n_own;
            r_partner   <= n_partner;
        end
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/cfvu_checker.sv @@
`include "command_frame_validator_unit_assert.svh"

module cfvu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cfvu_pkg::t_out_item o_out_data
);

    `CFVU_ASSERT_RESET(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")

    `CFVU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    `CFVU_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without output back-pressure")

    `CFVU_ASSERT_NOW(a_ack_bare, o_out_valid && o_out_data.result_kind == cfvu_pkg::KIND_ACK, o_out_data.event_type == 4'd0 && o_out_data.bank_select == 2'd0 && o_out_data.flag_bits == 8'd0 && o_out_data.word_a == 32'd0 && o_out_data.word_b == 32'd0, "ack carries event fields")

    `CFVU_ASSERT_NOW(a_event_ok, o_out_valid && o_out_data.result_kind == cfvu_pkg::KIND_EVENT, o_out_data.ack_status == cfvu_pkg::ACK_OK, "event with nonzero ack status")

endmodule

bind command_frame_validator_unit cfvu_checker u_cfvu_checker (.*);
